[rtl/core/assert_macros.svh]
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define MBP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition that must never be seen outside reset
`define MBP_ASSERT_NEVER(lbl, cond, msg) \
  `MBP_ASSERT(lbl, !(cond), msg)

`endif

[rtl/core/mbp_pkg.sv]
// ----------------------------------------------------------------------------
// mbp_pkg
// Types and constants of the msb-first bit packer.
// ----------------------------------------------------------------------------
`default_nettype none

package mbp_pkg;

  localparam int unsigned FieldWidth = 64;
  localparam int unsigned BufBits    = FieldWidth + 8;
  localparam int unsigned CntBits    = 4;

  typedef struct packed {
    logic [6:0]            bit_count;
    logic [FieldWidth-1:0] field_value;
    logic [5:0]            start_bit;
    logic                  flush;
  } mbp_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       stream_end;
  } mbp_out_t;

  typedef struct packed {
    logic [BufBits-1:0] bytes;
    logic [CntBits-1:0] nbytes;
    logic               flush;
    logic [6:0]         part_bits;
    logic [2:0]         part_cnt;
  } mbp_load_t;

endpackage

`default_nettype wire

[rtl/core/mbp_merge.sv]
// ----------------------------------------------------------------------------
// mbp_merge
// Extracts the requested bit field, joins it to the pending bits and
// returns the byte-aligned run, its byte count and the next pending bits.
// ----------------------------------------------------------------------------
`default_nettype none

module mbp_merge #(
  parameter int unsigned WORD_WIDTH = 64
) (
  input  wire mbp_pkg::mbp_in_t  req_i,
  input  wire logic [6:0]        part_bits_i,
  input  wire logic [2:0]        part_cnt_i,
  output      mbp_pkg::mbp_load_t load_o
);

  localparam int unsigned FW = mbp_pkg::FieldWidth;
  localparam int unsigned BW = mbp_pkg::BufBits;
  localparam logic [FW-1:0] WordMask = {FW{1'b1}} >> (FW - WORD_WIDTH);

  logic [7:0]    span;
  logic          fld_ok;
  logic [FW-1:0] word_m;
  logic [6:0]    lsh;
  logic [FW-1:0] f_left;
  logic [6:0]    n_eff;
  logic [7:0]    ptop;
  logic [BW-1:0] run;
  logic [BW-1:0] tail;
  logic [6:0]    total;
  logic [3:0]    full;
  logic [2:0]    rem;
  logic [7:0]    rem_byte;

  always_comb begin
    span   = {2'b00, req_i.start_bit} + {1'b0, req_i.bit_count};
    fld_ok = (req_i.bit_count != 7'd0) && (req_i.bit_count <= 7'(FW))
             && (span <= 8'(WORD_WIDTH));
    word_m = req_i.field_value & WordMask;
    lsh    = 7'(FW) - span[6:0];
    n_eff  = fld_ok ? req_i.bit_count : 7'd0;
    f_left = fld_ok ? ((word_m << lsh) & ~({FW{1'b1}} >> req_i.bit_count)) : '0;

    ptop  = 8'({1'b0, part_bits_i} << (4'd8 - {1'b0, part_cnt_i}));
    run   = {ptop, {FW{1'b0}}} | ({f_left, 8'h00} >> part_cnt_i);
    total = {4'b0000, part_cnt_i} + n_eff;
    full  = total[6:3];
    rem   = total[2:0];

    tail     = run << {full, 3'b000};
    rem_byte = tail[BW-1 -: 8] >> (4'd8 - {1'b0, rem});

    load_o.bytes  = run;
    load_o.nbytes = full + {3'b000, (req_i.flush && (rem != 3'd0))};
    load_o.flush  = req_i.flush;
    load_o.part_bits = req_i.flush ? 7'd0 : rem_byte[6:0];
    load_o.part_cnt  = req_i.flush ? 3'd0 : rem;
  end

endmodule

`default_nettype wire

[rtl/core/msb_first_bit_packer_unit.sv]
// ----------------------------------------------------------------------------
// msb_first_bit_packer_unit
// Appends bit fields msb first to a byte stream and emits completed bytes; a flush also emits the partial last byte.
// ----------------------------------------------------------------------------
// channel | direction | handshake                | payload
// in      | input     | in_valid_i / in_ready_o  | in_req_i  (mbp_in_t)
// out     | output    | out_valid_o / out_ready_i| out_req_o (mbp_out_t)
//
// a request is merged with the pending bits in the cycle it is accepted.
// a request producing k bytes, k up to 9, holds the byte shifter until its bytes have
// moved out; one byte leaves per cycle through the output register while the output is not stalled.
// the next request is taken in the cycle the last byte moves out.
// output stalls hold the byte register and the shifter; reset empties both
// and clears the pending bits.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module msb_first_bit_packer_unit #(
  parameter int unsigned WORD_WIDTH = 64
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output      logic              in_ready_o,
  input  wire mbp_pkg::mbp_in_t  in_req_i,
  output      logic              out_valid_o,
  input  wire logic              out_ready_i,
  output      mbp_pkg::mbp_out_t out_req_o
);

  localparam int unsigned BW = mbp_pkg::BufBits;

  mbp_pkg::mbp_load_t load;

  logic [6:0]              part_bits_q;
  logic [2:0]              part_cnt_q;
  logic [BW-1:0]           run_q;
  logic [mbp_pkg::CntBits-1:0] cnt_q;
  logic                    flush_q;
  logic                    out_valid_q;
  mbp_pkg::mbp_out_t       out_q;
  logic                    out_load;
  logic                    in_fire;

  mbp_merge #(
    .WORD_WIDTH(WORD_WIDTH)
  ) u_merge (
    .req_i      (in_req_i),
    .part_bits_i(part_bits_q),
    .part_cnt_i (part_cnt_q),
    .load_o     (load)
  );

  assign out_load   = !out_valid_q || out_ready_i;
  assign in_ready_o = (cnt_q == '0) || ((cnt_q == 4'd1) && out_load);
  assign in_fire    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      part_bits_q <= '0;
      part_cnt_q  <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        part_bits_q <= load.part_bits;
        part_cnt_q  <= load.part_cnt;
        cnt_q       <= load.nbytes;
      end else if (out_load && (cnt_q != '0)) begin
        cnt_q <= cnt_q - 4'd1;
      end
      if (out_load) begin
        out_valid_q <= (cnt_q != '0);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      run_q   <= load.bytes;
      flush_q <= load.flush;
    end else if (out_load && (cnt_q != '0)) begin
      run_q <= run_q << 8;
    end
    if (out_load && (cnt_q != '0)) begin
      out_q.out_byte   <= run_q[BW-1 -: 8];
      out_q.run_last   <= (cnt_q == 4'd1);
      out_q.stream_end <= (cnt_q == 4'd1) && flush_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

  `MBP_ASSERT(a_end_is_last, out_valid_o && out_req_o.stream_end |-> out_req_o.run_last, "stream end not on last byte")
  `MBP_ASSERT(a_flush_empties, in_fire && in_req_i.flush |=> (part_cnt_q == 3'd0) && (part_bits_q == 7'd0), "pending bits survive flush")
  `MBP_ASSERT_NEVER(a_cnt_range, cnt_q > 4'd9, "byte count out of range")
  `MBP_ASSERT(a_no_overrun, in_fire |-> (cnt_q <= 4'd1), "request taken over pending bytes")

endmodule

`default_nettype wire
